[rtl/bse_pkg.sv]
// Package for the bitmap set engine: command codes, transfer payload types
// and the result type of the shared word unit. No dependencies.
package bse_pkg;

    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned BIT_W     = 6;

    localparam logic [3:0] CMD_CLEAR         = 4'd0;
    localparam logic [3:0] CMD_INSERT        = 4'd1;
    localparam logic [3:0] CMD_CONTAIN       = 4'd2;
    localparam logic [3:0] CMD_ITER_START    = 4'd3;
    localparam logic [3:0] CMD_FIND_NEXT     = 4'd4;
    localparam logic [3:0] CMD_INTERSECT     = 4'd5;
    localparam logic [3:0] CMD_DIFFERENCE    = 4'd6;
    localparam logic [3:0] CMD_OTHER_SUBSET  = 4'd7;
    localparam logic [3:0] CMD_STORED_SUBSET = 4'd8;

    typedef struct packed {
        logic [3:0]           cmd;
        logic [9:0]           value;
        logic [3:0]           word_index;
        logic [WORD_BITS-1:0] other_word;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic [9:0] position;
        logic       at_end;
        logic       subset_ok;
        logic       range_error;
    } t_out_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 hit;
        logic                 ok;
        logic                 found;
        logic [BIT_W-1:0]     idx;
    } t_wu_res;

endpackage

[rtl/bse_store.sv]
// Bitmap word store: one write port and one read port with registered data.
// Depends on bse_pkg.
module bse_store
    import bse_pkg::*;
#(
    parameter int unsigned WORDS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] i_waddr,
    input  logic [WORD_BITS-1:0]           i_wdata,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] i_raddr,
    output logic [WORD_BITS-1:0]           o_rdata
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bse_word_unit.sv]
// Shared word unit: bit set and test, word merge, subset compare and the
// lowest-set-bit search of one bitmap word. Depends on bse_pkg.
module bse_word_unit
    import bse_pkg::*;
(
    input  logic [3:0]           i_cmd,
    input  logic [WORD_BITS-1:0] i_mine,
    input  logic [WORD_BITS-1:0] i_other,
    input  logic [BIT_W-1:0]     i_bit,
    input  logic                 i_first,
    output t_wu_res              o_res
);

    always_comb begin
        logic [WORD_BITS-1:0] sel_bit;
        logic [WORD_BITS-1:0] masked;
        logic [WORD_BITS-1:0] lowest;
        logic [WORD_BITS-1:0] common;
        logic [BIT_W-1:0]     idx;

        sel_bit  = {{(WORD_BITS-1){1'b0}}, 1'b1} << i_bit;
        masked   = i_first ? (i_mine & ({WORD_BITS{1'b1}} << i_bit)) : i_mine;
        lowest   = masked & (~masked + {{(WORD_BITS-1){1'b0}}, 1'b1});
        common   = i_mine & i_other;

        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                idx = idx | BIT_W'(i);
            end
        end

        o_res.idx   = idx;
        o_res.found = |masked;
        o_res.hit   = |(i_mine & sel_bit);
        o_res.ok    = (i_cmd == CMD_OTHER_SUBSET) ? (common == i_other) : (common == i_mine);

        case (i_cmd)
            CMD_INSERT:     o_res.word = i_mine | sel_bit;
            CMD_INTERSECT:  o_res.word = common;
            CMD_DIFFERENCE: o_res.word = i_mine & ~i_other;
            default:        o_res.word = i_mine;
        endcase
    end

endmodule

[rtl/bitmap_set_engine_unit.sv]
// Top level of the bitmap set engine: command sequencer, cursor, subset flag
// and output register. Depends on bse_pkg, bse_store and bse_word_unit.
//
// The engine holds a set of WORDS*64 elements in a single-port-read word
// store and takes one command per transfer, giving one result per command.
// After reset the store is swept to zero, one word per cycle, and no command
// is taken during the sweep; a clear command runs the same sweep and then
// presents its result. Insert and the intersect and difference commands read
// one word, work on it and write it back; contain and the two subset commands
// read one word and write nothing back. A find-next command reads one word at
// a time from the cursor onward, passing through a read state and a scan state
// for each word; the registered store read sets that pace. A finished result
// waits in the output register while the next command is already taken.
module bitmap_set_engine_unit
    import bse_pkg::*;
#(
    parameter int unsigned WORDS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned TOTAL = WORDS * WORD_BITS;
    localparam int unsigned CW    = $clog2(TOTAL + 1);
    localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state,     n_state;
    logic [AW-1:0]         r_addr,      n_addr;
    logic                  r_clr_resp,  n_clr_resp;
    logic [3:0]            r_cmd,       n_cmd;
    logic [BIT_W-1:0]      r_bit,       n_bit;
    logic                  r_widx_zero, n_widx_zero;
    logic [WORD_BITS-1:0]  r_other,     n_other;
    logic                  r_first,     n_first;
    logic [CW-1:0]         r_cursor,    n_cursor;
    logic                  r_subset,    n_subset;
    t_out_item             r_res,       n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out,       n_out;

    logic                  in_fire;
    logic                  mem_we;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [WORD_BITS-1:0]  mem_rdata;
    t_wu_res               wu;
    logic [AW+BIT_W-1:0]   found_pos;

    bse_store #(
        .WORDS(WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_addr),
        .i_wdata(mem_wdata),
        .i_raddr(r_addr),
        .o_rdata(mem_rdata)
    );

    bse_word_unit u_word_unit (
        .i_cmd  (r_cmd),
        .i_mine (mem_rdata),
        .i_other(r_other),
        .i_bit  (r_bit),
        .i_first(r_first),
        .o_res  (wu)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign found_pos   = {r_addr, wu.idx};

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = wu.word;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end else if (r_state == S_EXEC) begin
            mem_we = (r_cmd == CMD_INSERT) || (r_cmd == CMD_INTERSECT)
                  || (r_cmd == CMD_DIFFERENCE);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_clr_resp  = r_clr_resp;
        n_cmd       = r_cmd;
        n_bit       = r_bit;
        n_widx_zero = r_widx_zero;
        n_other     = r_other;
        n_first     = r_first;
        n_cursor    = r_cursor;
        n_subset    = r_subset;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd       = i_in.cmd;
                    n_other     = i_in.other_word;
                    n_widx_zero = (i_in.word_index == 4'd0);
                    n_res       = '0;
                    n_first     = 1'b0;
                    n_state     = S_DONE;
                    case (i_in.cmd)
                        CMD_CLEAR: begin
                            n_addr     = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        CMD_INSERT, CMD_CONTAIN: begin
                            if (32'(i_in.value) >= TOTAL) begin
                                n_res.range_error = 1'b1;
                            end else begin
                                n_addr  = AW'(i_in.value >> BIT_W);
                                n_bit   = i_in.value[BIT_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        CMD_ITER_START: begin
                            n_cursor = '0;
                        end
                        CMD_FIND_NEXT: begin
                            if (32'(r_cursor) >= TOTAL) begin
                                n_res.at_end = 1'b1;
                            end else begin
                                n_addr  = AW'(r_cursor >> BIT_W);
                                n_bit   = r_cursor[BIT_W-1:0];
                                n_first = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        CMD_INTERSECT, CMD_DIFFERENCE, CMD_OTHER_SUBSET,
                        CMD_STORED_SUBSET: begin
                            if (32'(i_in.word_index) >= WORDS) begin
                                n_res.range_error = 1'b1;
                            end else begin
                                n_addr  = AW'(i_in.word_index);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = (r_cmd == CMD_FIND_NEXT) ? S_SCAN : S_EXEC;
            end
            S_EXEC: begin
                if ((r_cmd == CMD_INSERT) || (r_cmd == CMD_CONTAIN)) begin
                    n_res.hit = wu.hit;
                end
                if ((r_cmd == CMD_OTHER_SUBSET) || (r_cmd == CMD_STORED_SUBSET)) begin
                    n_subset = (r_widx_zero || r_subset) && wu.ok;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                n_first = 1'b0;
                if (wu.found) begin
                    n_res.position = 10'(found_pos);
                    n_cursor       = CW'(found_pos) + CW'(1);
                    n_state        = S_DONE;
                end else if (r_addr == LAST) begin
                    n_res.at_end = 1'b1;
                    n_cursor     = CW'(TOTAL);
                    n_state      = S_DONE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_addr     = '0;
                    n_clr_resp = 1'b0;
                    n_state    = r_clr_resp ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out           = r_res;
                    n_out.subset_ok = r_subset;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_clr_resp  <= 1'b0;
            r_first     <= 1'b0;
            r_cursor    <= '0;
            r_subset    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_clr_resp  <= n_clr_resp;
            r_first     <= n_first;
            r_cursor    <= n_cursor;
            r_subset    <= n_subset;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_bit       <= n_bit;
        r_widx_zero <= n_widx_zero;
        r_other     <= n_other;
        r_res       <= n_res;
        r_out       <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) <= TOTAL)
        else $error("Iteration cursor passed the end mark.");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("Word store written while no command is in progress.");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.cmd == CMD_CLEAR)) |=> (r_state == S_CLEAR) && (r_addr == '0))
        else $error("Clear command did not start its sweep at word zero.");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("Finished command did not present its result.");
`endif

endmodule

[tb/bse_result_checker.sv]
// Checker for the bitmap set engine: watches both channels, predicts each
// result from its own copy of the set, cursor and subset flag, and compares.
// Depends on bse_pkg.
module bse_result_checker
    import bse_pkg::*;
#(
    parameter int unsigned WORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out,
    output int unsigned o_pending,
    output int unsigned o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TOTAL_BITS = WORDS * WORD_BITS;
    localparam int unsigned CURSOR_W   = $clog2(TOTAL_BITS) + 1;

    logic [WORD_BITS-1:0] stored_words [WORDS];
    logic [CURSOR_W-1:0]  iter_cursor;
    logic                 subset_run;
    t_out_item            awaited_responses [$];
    int unsigned          results_seen;

    task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        o_mismatches++;
        $display("%0t: result %0d %s: expected %0h, got %0h",
                 $time, results_seen, field, want_v, got_v);
    endtask

    function automatic t_out_item set_engine_response(input t_in_item it);
        t_out_item            r;
        logic [WORD_BITS-1:0] mine;
        logic                 ok;
        logic                 found;
        int unsigned          spot;
        r     = '0;
        found = 1'b0;
        spot  = 0;
        case (it.cmd)
            CMD_CLEAR: begin
                for (int w = 0; w < WORDS; w++) stored_words[w] = '0;
            end
            CMD_INSERT, CMD_CONTAIN: begin
                if (it.value >= TOTAL_BITS) begin
                    r.range_error = 1'b1;
                end else begin
                    r.hit = stored_words[it.value / WORD_BITS][it.value % WORD_BITS];
                    if (it.cmd == CMD_INSERT) begin
                        stored_words[it.value / WORD_BITS][it.value % WORD_BITS] = 1'b1;
                    end
                end
            end
            CMD_ITER_START: begin
                iter_cursor = '0;
            end
            CMD_FIND_NEXT: begin
                for (int unsigned b = iter_cursor; b < TOTAL_BITS; b++) begin
                    if (!found && stored_words[b / WORD_BITS][b % WORD_BITS]) begin
                        found = 1'b1;
                        spot  = b;
                    end
                end
                if (found) begin
                    r.position  = 10'(spot);
                    iter_cursor = CURSOR_W'(spot + 1);
                end else begin
                    r.at_end    = 1'b1;
                    iter_cursor = CURSOR_W'(TOTAL_BITS);
                end
            end
            CMD_INTERSECT, CMD_DIFFERENCE, CMD_OTHER_SUBSET, CMD_STORED_SUBSET: begin
                if (it.word_index >= WORDS) begin
                    r.range_error = 1'b1;
                end else begin
                    mine = stored_words[it.word_index];
                    if (it.cmd == CMD_INTERSECT) begin
                        stored_words[it.word_index] = mine & it.other_word;
                    end else if (it.cmd == CMD_DIFFERENCE) begin
                        stored_words[it.word_index] = mine & ~it.other_word;
                    end else begin
                        ok = (it.cmd == CMD_OTHER_SUBSET) ?
                             ((mine & it.other_word) == it.other_word) :
                             ((mine & it.other_word) == mine);
                        if (it.word_index == 0) subset_run = 1'b1;
                        subset_run = subset_run & ok;
                    end
                end
            end
            default: begin
            end
        endcase
        r.subset_ok = subset_run;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) stored_words[w] = '0;
            iter_cursor = '0;
            subset_run  = 1'b1;
            awaited_responses.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_responses.push_back(set_engine_response(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_responses.size() == 0) begin
                    report_mismatch("unexpected result", '0, 64'(i_out));
                end else begin
                    want = awaited_responses.pop_front();
                    if (i_out.hit !== want.hit)
                        report_mismatch("hit", want.hit, i_out.hit);
                    if (i_out.position !== want.position)
                        report_mismatch("position", want.position, i_out.position);
                    if (i_out.at_end !== want.at_end)
                        report_mismatch("at_end", want.at_end, i_out.at_end);
                    if (i_out.subset_ok !== want.subset_ok)
                        report_mismatch("subset_ok", want.subset_ok, i_out.subset_ok);
                    if (i_out.range_error !== want.range_error)
                        report_mismatch("range_error", want.range_error, i_out.range_error);
                end
                results_seen++;
            end
            o_pending <= awaited_responses.size();
        end
    end

endmodule

[tb/tb_bitmap_set_engine_unit.sv]
// Top of the bitmap set engine testbench: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on bse_pkg, bitmap_set_engine_unit
// and bse_result_checker.
module tb_bitmap_set_engine_unit
    import bse_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SET_WORDS    = 16;
    localparam int unsigned ITEM_TARGET  = 950;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    int unsigned pending;
    int unsigned mismatches;

    int unsigned items_sent         = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    logic [9:0]  hot_element        = '0;

    bitmap_set_engine_unit #(
        .WORDS(SET_WORDS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    bse_result_checker #(
        .WORDS(SET_WORDS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_command(input logic [3:0] op, input logic [9:0] element,
                                input logic [3:0] widx, input logic [63:0] word);
        t_in_item it;
        it.cmd        = op;
        it.value      = element;
        it.word_index = widx;
        it.other_word = word;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [63:0] pick_other_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            3:       return 64'd1 << $urandom_range(63);
            4:       return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [9:0] pick_element();
        case ($urandom_range(3))
            0:       return 10'($urandom);
            1:       return {4'($urandom), {6{1'($urandom)}}};
            default: return 10'(hot_element + $urandom_range(31));
        endcase
    endfunction

    initial begin
        int unsigned kind;
        int unsigned span;
        int unsigned first_word;
        logic [3:0]  op;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_command(CMD_CLEAR, 10'd0, 4'd0, '0);
        send_command(CMD_INSERT, 10'd0, 4'd0, '0);
        send_command(CMD_INSERT, 10'd1023, 4'd15, '1);
        send_command(CMD_INSERT, 10'd0, 4'd0, '0);
        send_command(CMD_CONTAIN, 10'd1023, 4'd0, '0);
        send_command(CMD_CONTAIN, 10'd512, 4'd0, '0);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_ITER_START, 10'd1023, 4'd15, '1);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_INSERT, 10'd700, 4'd0, '0);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_ITER_START, 10'd0, 4'd0, '0);
        send_command(CMD_OTHER_SUBSET, 10'd0, 4'd0, '0);
        send_command(CMD_STORED_SUBSET, 10'd0, 4'd15, '0);
        send_command(CMD_STORED_SUBSET, 10'd0, 4'd0, '1);
        send_command(CMD_INTERSECT, 10'd0, 4'd15, '1);
        send_command(CMD_DIFFERENCE, 10'd0, 4'd0, '1);
        send_command(CMD_INTERSECT, 10'd0, 4'd10, '0);
        send_command(4'd9, 10'h3FF, 4'hF, '1);
        send_command(4'd15, 10'h3FF, 4'hF, '1);
        send_command(CMD_CONTAIN, 10'd0, 4'd0, '0);
        send_command(CMD_FIND_NEXT, 10'd0, 4'd0, '0);
        send_command(CMD_CLEAR, 10'h3FF, 4'hF, '1);

        while (items_sent < ITEM_TARGET) begin
            case ((items_sent / 120) % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct    = 47;
                    receiver_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 47;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct <= 7;
                end
            endcase
            kind = $urandom_range(31);
            if (kind == 0) begin
                send_command(CMD_CLEAR, 10'($urandom), 4'($urandom), {$urandom, $urandom});
            end else if (kind <= 10) begin
                hot_element = 10'($urandom);
                span = $urandom_range(24, 4);
                repeat (span) begin
                    op = ($urandom_range(3) == 0) ? CMD_CONTAIN : CMD_INSERT;
                    send_command(op, pick_element(), 4'($urandom), {$urandom, $urandom});
                end
            end else if (kind <= 17) begin
                if ($urandom_range(4) != 0) begin
                    send_command(CMD_ITER_START, 10'($urandom), 4'($urandom),
                                 {$urandom, $urandom});
                end
                span = $urandom_range(24, 1);
                repeat (span) begin
                    if ($urandom_range(7) == 0) begin
                        send_command(CMD_INSERT, pick_element(), 4'($urandom),
                                     {$urandom, $urandom});
                    end
                    send_command(CMD_FIND_NEXT, 10'($urandom), 4'($urandom),
                                 {$urandom, $urandom});
                end
            end else if (kind <= 24) begin
                op = ($urandom_range(1) == 0) ? CMD_OTHER_SUBSET : CMD_STORED_SUBSET;
                first_word = ($urandom_range(3) == 0) ? $urandom_range(SET_WORDS - 1) : 0;
                span = ($urandom_range(3) == 0) ? $urandom_range(SET_WORDS) : SET_WORDS;
                for (int w = first_word; w < SET_WORDS && w < first_word + span; w++) begin
                    send_command(op, 10'($urandom), 4'(w),
                                 ($urandom_range(15) != 0) ?
                                 ((op == CMD_OTHER_SUBSET) ? 64'd0 : '1) :
                                 pick_other_word());
                end
            end else if (kind <= 28) begin
                op = ($urandom_range(1) == 0) ? CMD_INTERSECT : CMD_DIFFERENCE;
                send_command(op, 10'($urandom), 4'($urandom), pick_other_word());
            end else begin
                send_command(4'($urandom), 10'($urandom), 4'($urandom),
                             {$urandom, $urandom});
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatches == 0) begin
            $display("bitmap_set_engine_unit regression: pass");
        end else begin
            $display("bitmap_set_engine_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("bitmap_set_engine_unit regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/bse_pkg.sv
rtl/bse_store.sv
rtl/bse_word_unit.sv
rtl/bitmap_set_engine_unit.sv
tb/bse_result_checker.sv
tb/tb_bitmap_set_engine_unit.sv
